>>> hw/rtl/ljpe_pkg.sv
// Shared types and constants for the Lennard-Jones pair energy accumulator.
// No dependencies; imported by the multiplier, the checker and the top level.
package ljpe_pkg;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIFF,
    S_SQ,
    S_CMP,
    S_CUBE1,
    S_CUBE2,
    S_CUBE3,
    S_DCHK,
    S_DIV,
    S_ETERM,
    S_VTERM,
    S_EMIT
  } ljpe_state_t;

  typedef enum logic [0:0] {
    REG_BOX_LENGTH = 1'b0,
    REG_CUTOFF_SQ  = 1'b1
  } ljpe_reg_t;

  localparam int          SUM_W      = 48;
  localparam int          BOX_W      = 24;
  localparam int          CUT_W      = 32;
  localparam int          MUL_W      = 33;
  localparam int          R6I_W      = 30;
  localparam int          QBITS      = 29;
  localparam int          DCUBE_W    = 96;
  localparam logic [23:0] BOX_RESET  = 24'd565248;
  localparam logic [31:0] CUT_RESET  = 32'd1048576;
  localparam logic [29:0] R6I_CAP    = 30'h2000_0000;
  localparam logic [49:0] FAR_SQ     = 50'h1_0000_0000_0000;
  localparam logic signed [49:0] SUM_MAX = 50'sh0_7FFF_FFFF_FFFF;
  localparam logic signed [49:0] SUM_MIN = -50'sh0_8000_0000_0000;

endpackage

>>> hw/rtl/lennard_jones_pair_energy_accumulator_unit.sv
// Lennard-Jones 12-6 pair energy/virial accumulator, one shared multiplier.
// Pair paths: a self pair goes straight to emit, a pair outside the cutoff ends after
// the compare, r6i is capped when r2 is below 2 or r2 cubed is at most 2^35, and a full
// pair runs the 29-step restoring divider for 1/r2^3 after the single multiplier.
// A last pair also holds in the emit step while an earlier result still waits.
// One pair in flight at a time. Reset (rst_n low, synchronous) clears sums, flag,
// sequencer and output valid; config registers return to box 8.625, cutoff_sq 16.0.
module lennard_jones_pair_energy_accumulator_unit import ljpe_pkg::*; #(
  parameter int COORD_WIDTH = 24
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // in_tdata: ref_x, ref_y, ref_z, nbr_x, nbr_y, nbr_z (lowest first), zero padded
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [((6*COORD_WIDTH+7)/8)*8-1:0] in_tdata,
  input  logic                  in_tlast,   // last_pair
  input  logic                  in_tuser,   // is_self
  // out_tdata: energy_sum [47:0], virial_sum [95:48]
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [2*SUM_W-1:0]    out_tdata,
  output logic                  out_tuser,  // saturated
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [2:0]            cfg_paddr,
  input  logic [31:0]           cfg_pwdata,
  output logic [31:0]           cfg_prdata,
  output logic                  cfg_pready
);

  // Difference width: room for 2*d and for the box length.
  localparam int CW = COORD_WIDTH;
  localparam int DW = ((CW > BOX_W) ? CW : BOX_W) + 3;

  ljpe_state_t state_r, state_nxt;

  logic [BOX_W-1:0] box_r;
  logic [CUT_W-1:0] cut_r;

  logic [CW-1:0] ref_x_r, ref_y_r, ref_z_r, nbr_x_r, nbr_y_r, nbr_z_r;
  logic          last_r;
  logic [1:0]    ax_r;
  logic [31:0]   mag_r;
  logic          far_r;
  logic [49:0]   r2_r;
  logic [63:0]   rsq_r;
  logic [63:0]   lo_r;
  logic [DCUBE_W-1:0] dcube_r;
  logic [DCUBE_W:0]   rem_r;
  logic [QBITS-1:0]   q_r;
  logic [4:0]    cnt_r;
  logic [R6I_W-1:0]   r6i_r;
  logic signed [SUM_W-1:0] e_acc_r, v_acc_r;
  logic          sat_r;
  logic          out_valid_r;
  logic [2*SUM_W-1:0] out_data_r;
  logic          out_sat_r;

  // ---------------- configuration port ----------------
  logic cfg_wr;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite;
  assign cfg_pready = 1'b1;

  always_comb begin
    unique case (ljpe_reg_t'(cfg_paddr[2]))
      REG_BOX_LENGTH: cfg_prdata = {8'd0, box_r};
      REG_CUTOFF_SQ:  cfg_prdata = cut_r;
      default:        cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      box_r <= BOX_RESET;
      cut_r <= CUT_RESET;
    end else if (cfg_wr) begin
      unique case (ljpe_reg_t'(cfg_paddr[2]))
        REG_BOX_LENGTH: box_r <= cfg_pwdata[BOX_W-1:0];
        REG_CUTOFF_SQ:  cut_r <= cfg_pwdata;
        default:        ;
      endcase
    end
  end

  // ---------------- axis fold to nearest image ----------------
  logic [CW-1:0]        ca, cb;
  logic signed [DW-1:0] d, d2, len, dfold;
  logic [DW-1:0]        mag;
  logic [63:0]          mag64;

  always_comb begin
    case (ax_r)
      2'd0:    begin ca = ref_x_r; cb = nbr_x_r; end
      2'd1:    begin ca = ref_y_r; cb = nbr_y_r; end
      default: begin ca = ref_z_r; cb = nbr_z_r; end
    endcase
    d   = $signed(DW'(cb)) - $signed(DW'(ca));
    d2  = d <<< 1;
    len = $signed(DW'(box_r));
    if (d2 > len)       dfold = d - len;
    else if (d2 < -len) dfold = d + len;
    else                dfold = d;
    mag   = dfold[DW-1] ? DW'(-dfold) : DW'(dfold);
    mag64 = 64'(mag);
  end

  // ---------------- shared multiplier ----------------
  logic signed [MUL_W-1:0]   mul_a, mul_b;
  logic signed [2*MUL_W-1:0] mul_p;
  logic [31:0]               rr;

  assign rr = r2_r[31:0];

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_SQ:    begin mul_a = {1'b0, mag_r};       mul_b = {1'b0, mag_r}; end
      S_CUBE1: begin mul_a = {1'b0, rr};          mul_b = {1'b0, rr}; end
      S_CUBE2: begin mul_a = {1'b0, rsq_r[31:0]}; mul_b = {1'b0, rr}; end
      S_CUBE3: begin mul_a = {1'b0, rsq_r[63:32]}; mul_b = {1'b0, rr}; end
      S_ETERM: begin
        mul_a = $signed({3'b0, r6i_r});
        mul_b = $signed({3'b0, r6i_r}) - 33'sd65536;
      end
      S_VTERM: begin
        mul_a = $signed({3'b0, r6i_r});
        mul_b = $signed({3'b0, r6i_r}) - 33'sd32768;
      end
      default: ;
    endcase
  end

  ljpe_mul u_mul (
    .a (mul_a),
    .b (mul_b),
    .p (mul_p)
  );

  // ---------------- term and saturating add ----------------
  // 4*p/2^16 and 16*p/2^16, arithmetic shift rounds toward minus infinity.
  logic signed [2*MUL_W-1:0] e_sh, v_sh;
  logic signed [49:0]        term, acc_ext, sum_raw, sum_sat;
  logic                      sum_ovf;

  always_comb begin
    e_sh    = mul_p >>> 14;
    v_sh    = mul_p >>> 12;
    term    = (state_r == S_ETERM) ? e_sh[49:0] : v_sh[49:0];
    acc_ext = (state_r == S_ETERM) ? 50'(e_acc_r) : 50'(v_acc_r);
    sum_raw = acc_ext + term;
    sum_ovf = 1'b1;
    if (sum_raw > SUM_MAX)      sum_sat = SUM_MAX;
    else if (sum_raw < SUM_MIN) sum_sat = SUM_MIN;
    else begin
      sum_sat = sum_raw;
      sum_ovf = 1'b0;
    end
  end

  // ---------------- divider step and cap check ----------------
  logic [DCUBE_W:0] rem_sh;
  logic             q_bit;
  logic             small_d;
  logic [65:0]      cap_t;

  always_comb begin
    rem_sh  = {rem_r[DCUBE_W-1:0], 1'b0};
    q_bit   = rem_sh >= {1'b0, dcube_r};
    small_d = dcube_r <= (DCUBE_W'(1) << 35);
    // quotient above 2^29 exactly when D*(2^29+1) <= 2^64
    cap_t   = {dcube_r[35:0], 29'd0} + 66'(dcube_r[35:0]);
  end

  // ---------------- sequencer ----------------
  logic emit_go;
  assign emit_go = last_r && !out_valid_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_tvalid) state_nxt = in_tuser ? S_EMIT : S_DIFF;
      S_DIFF:  state_nxt = S_SQ;
      S_SQ:    state_nxt = (ax_r == 2'd2) ? S_CMP : S_DIFF;
      S_CMP: begin
        if (r2_r >= 50'(cut_r)) state_nxt = S_EMIT;
        else if (rr < 32'd2)    state_nxt = S_ETERM;
        else                    state_nxt = S_CUBE1;
      end
      S_CUBE1: state_nxt = S_CUBE2;
      S_CUBE2: state_nxt = S_CUBE3;
      S_CUBE3: state_nxt = S_DCHK;
      S_DCHK:  state_nxt = small_d ? S_ETERM : S_DIV;
      S_DIV:   if (cnt_r == 5'd0) state_nxt = S_ETERM;
      S_ETERM: state_nxt = S_VTERM;
      S_VTERM: state_nxt = S_EMIT;
      S_EMIT:  if (!last_r || emit_go) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  // ---------------- datapath ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_acc_r     <= '0;
      v_acc_r     <= '0;
      sat_r       <= 1'b0;
      out_valid_r <= 1'b0;
      ax_r        <= '0;
      cnt_r       <= '0;
    end else begin
      if (out_valid_r && out_tready) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: if (in_tvalid) begin
          ref_x_r <= in_tdata[0*CW +: CW];
          ref_y_r <= in_tdata[1*CW +: CW];
          ref_z_r <= in_tdata[2*CW +: CW];
          nbr_x_r <= in_tdata[3*CW +: CW];
          nbr_y_r <= in_tdata[4*CW +: CW];
          nbr_z_r <= in_tdata[5*CW +: CW];
          last_r  <= in_tlast;
          ax_r    <= '0;
          r2_r    <= '0;
        end
        S_DIFF: begin
          mag_r <= mag64[31:0];
          far_r <= mag64[63:32] != 32'd0;
        end
        S_SQ: begin
          r2_r <= r2_r + (far_r ? FAR_SQ : 50'(mul_p[63:16]));
          ax_r <= ax_r + 2'd1;
        end
        S_CMP: if (r2_r < 50'(cut_r) && rr < 32'd2) begin
          r6i_r <= R6I_CAP;
          sat_r <= 1'b1;
        end
        S_CUBE1: rsq_r <= mul_p[63:0];
        S_CUBE2: lo_r  <= mul_p[63:0];
        S_CUBE3: dcube_r <= {mul_p[63:0], 32'd0} + DCUBE_W'(lo_r);
        S_DCHK: begin
          if (small_d) begin
            r6i_r <= R6I_CAP;
            if (cap_t <= 66'h1_0000_0000_0000_0000) sat_r <= 1'b1;
          end
          rem_r <= (DCUBE_W+1)'(1) << 35;
          q_r   <= '0;
          cnt_r <= 5'(QBITS - 1);
        end
        S_DIV: begin
          rem_r <= q_bit ? (rem_sh - {1'b0, dcube_r}) : rem_sh;
          q_r   <= {q_r[QBITS-2:0], q_bit};
          cnt_r <= cnt_r - 5'd1;
          if (cnt_r == 5'd0) r6i_r <= {1'b0, q_r[QBITS-2:0], q_bit};
        end
        S_ETERM: begin
          e_acc_r <= sum_sat[SUM_W-1:0];
          if (sum_ovf) sat_r <= 1'b1;
        end
        S_VTERM: begin
          v_acc_r <= sum_sat[SUM_W-1:0];
          if (sum_ovf) sat_r <= 1'b1;
        end
        S_EMIT: if (emit_go) begin
          // hold result in the output stage, clear the batch
          out_data_r  <= {v_acc_r, e_acc_r};
          out_sat_r   <= sat_r;
          out_valid_r <= 1'b1;
          e_acc_r     <= '0;
          v_acc_r     <= '0;
          sat_r       <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_sat_r;

endmodule

>>> hw/rtl/ljpe_mul.sv
// Shared signed 33x33 multiplier used by every multiply step.
// Depends on ljpe_pkg for the operand width.
module ljpe_mul import ljpe_pkg::*; (
  input  logic signed [MUL_W-1:0]   a,
  input  logic signed [MUL_W-1:0]   b,
  output logic signed [2*MUL_W-1:0] p
);

  assign p = a * b;

endmodule

>>> hw/rtl/ljpe_checker.sv
// Port-level checks for the pair energy accumulator, bound to the top level.
// Depends on ljpe_pkg for widths.
module ljpe_checker import ljpe_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_tvalid,
  input logic              in_tready,
  input logic              out_tvalid,
  input logic              out_tready,
  input logic [2*SUM_W-1:0] out_tdata,
  input logic              cfg_pready
);

  // one pair at a time: ready drops after each accepted transaction
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready) else $error("accepted while busy");

  // a taken result is not followed by another in the next cycle
  a_no_back_to_back_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready |=> !out_tvalid) else $error("result repeated");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && cfg_pready) else $error("reset state wrong");

endmodule

bind lennard_jones_pair_energy_accumulator_unit ljpe_checker u_ljpe_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .cfg_pready (cfg_pready)
);
